// ===== design/hkdp_pkg.sv =====
// ----------------------------------------------------------------------------
// hkdp_pkg
// Shared types and codes for the HID keyboard report descriptor parser.
// ----------------------------------------------------------------------------
package hkdp_pkg;

  typedef enum logic [1:0] {
    ITEM_MAIN     = 2'd0,
    ITEM_GLOBAL   = 2'd1,
    ITEM_LOCAL    = 2'd2,
    ITEM_RESERVED = 2'd3
  } item_kind_t;

  localparam logic [3:0] GTAG_PAGE       = 4'h0;
  localparam logic [3:0] GTAG_FIELD_BITS = 4'h7;
  localparam logic [3:0] GTAG_RPT_ID     = 4'h8;
  localparam logic [3:0] GTAG_FIELD_CNT  = 4'h9;
  localparam logic [3:0] LTAG_USG        = 4'h0;
  localparam logic [3:0] MTAG_IN_FIELD   = 4'h8;

  localparam logic [31:0] PAGE_DESKTOP  = 32'h01;
  localparam logic [31:0] PAGE_KEYBOARD = 32'h07;
  localparam logic [31:0] USAGE_KBD     = 32'h06;

  localparam int OFFSET_W = 30;

  // one assembled short item as handed from the framer to the executor
  typedef struct packed {
    item_kind_t  kind;
    logic [3:0]  tag;
    logic [31:0] data;
    logic        last;
  } item_t;

endpackage

// ===== design/hkdp_front.sv =====
// ----------------------------------------------------------------------------
// hkdp_front
// Byte framer: splits descriptor bytes into short items and emits each one.
// ----------------------------------------------------------------------------
module hkdp_front
  import hkdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_fire,
  input  logic [7:0] desc_byte,
  input  logic       last_byte,
  output logic       item_push,
  output item_t      item
);

  logic [2:0]  bytes_left, bytes_left_next;
  logic [1:0]  byte_index, byte_index_next;
  item_kind_t  kind, kind_next;
  logic [3:0]  tag, tag_next;
  logic [31:0] data, data_next;
  logic        done;

  always_comb begin
    bytes_left_next = bytes_left;
    byte_index_next = byte_index;
    kind_next       = kind;
    tag_next        = tag;
    data_next       = data;
    done            = 1'b0;
    if (bytes_left == 3'd0) begin
      // prefix byte
      unique case (desc_byte[1:0])
        2'd0:    bytes_left_next = 3'd0;
        2'd1:    bytes_left_next = 3'd1;
        2'd2:    bytes_left_next = 3'd2;
        default: bytes_left_next = 3'd4;
      endcase
      kind_next       = item_kind_t'(desc_byte[3:2]);
      tag_next        = desc_byte[7:4];
      data_next       = '0;
      byte_index_next = 2'd0;
      done            = (desc_byte[1:0] == 2'd0) || last_byte;
    end else begin
      data_next       = data | ({24'd0, desc_byte} << {byte_index, 3'b000});
      byte_index_next = byte_index + 2'd1;
      bytes_left_next = bytes_left - 3'd1;
      // a truncated item is flushed with what it has
      done            = (bytes_left == 3'd1) || last_byte;
    end
  end

  assign item_push = byte_fire && done;
  assign item      = '{kind: kind_next, tag: tag_next, data: data_next, last: last_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      byte_index <= '0;
      kind       <= ITEM_MAIN;
      tag        <= '0;
      data       <= '0;
    end else if (byte_fire) begin
      if (last_byte) begin
        bytes_left <= '0;
        byte_index <= '0;
        kind       <= ITEM_MAIN;
        tag        <= '0;
        data       <= '0;
      end else begin
        bytes_left <= bytes_left_next;
        byte_index <= byte_index_next;
        kind       <= kind_next;
        tag        <= tag_next;
        data       <= data_next;
      end
    end
  end

endmodule

// ===== design/hkdp_queue.sv =====
// ----------------------------------------------------------------------------
// hkdp_queue
// Two-entry item queue between the framer and the executor.
// ----------------------------------------------------------------------------
module hkdp_queue
  import hkdp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/hkdp_back.sv =====
// ----------------------------------------------------------------------------
// hkdp_back
// Item executor: tracks global state, locates keyboard fields, emits layout.
// ----------------------------------------------------------------------------
module hkdp_back
  import hkdp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  item_t        item,
  output logic         item_pop,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,
  output logic [0:0]   m_tuser
);

  logic [31:0]         usage_page, field_size, field_count;
  logic                kbd_seen, id_prefix;
  logic [31:0]         bit_pos;
  logic [31:0]         rpt_id;
  logic                mod_found, key_found;
  logic [OFFSET_W-1:0] mod_off, key_off;
  logic [31:0]         key_slots;
  // size times count, kept current one item ahead of its use
  logic [63:0]         product;

  logic [31:0]         usage_page_next, field_size_next, field_count_next;
  logic                kbd_seen_next, id_prefix_next;
  logic [31:0]         bit_pos_next, rpt_id_next, key_slots_next;
  logic                mod_found_next, key_found_next;
  logic [OFFSET_W-1:0] mod_off_next, key_off_next;
  logic [31:0]         mul_a, mul_b;
  logic                mul_load;

  logic                on_key_page, is_var, is_const;
  logic [OFFSET_W-1:0] offset;
  logic [32:0]         sum;

  logic                out_valid;
  logic                out_kbd;
  logic [31:0]         out_rpt_id, out_key_slots;
  logic [30:0]         out_mod_off, out_key_off;

  assign item_pop = item_valid && (!item.last || !out_valid || m_tready);

  assign on_key_page = (usage_page == PAGE_KEYBOARD);
  assign is_const    = item.data[0];
  assign is_var      = item.data[1];
  assign offset      = {{(OFFSET_W-1){1'b0}}, id_prefix} + {1'b0, bit_pos[31:3]};
  assign sum         = {1'b0, bit_pos} + {1'b0, product[31:0]};

  always_comb begin
    usage_page_next  = usage_page;
    field_size_next  = field_size;
    field_count_next = field_count;
    kbd_seen_next    = kbd_seen;
    id_prefix_next   = id_prefix;
    bit_pos_next     = bit_pos;
    rpt_id_next      = rpt_id;
    mod_found_next   = mod_found;
    key_found_next   = key_found;
    mod_off_next     = mod_off;
    key_off_next     = key_off;
    key_slots_next   = key_slots;
    mul_load         = 1'b0;
    mul_a            = field_size;
    mul_b            = field_count;
    unique case (item.kind)
      ITEM_GLOBAL: begin
        case (item.tag)
          GTAG_PAGE: usage_page_next = item.data;
          GTAG_FIELD_BITS: begin
            field_size_next = item.data;
            mul_load        = 1'b1;
            mul_a           = item.data;
          end
          GTAG_FIELD_CNT: begin
            field_count_next = item.data;
            mul_load         = 1'b1;
            mul_b            = item.data;
          end
          GTAG_RPT_ID: begin
            rpt_id_next    = item.data;
            id_prefix_next = 1'b1;
          end
          default: ;
        endcase
      end
      ITEM_LOCAL: begin
        if (item.tag == LTAG_USG && usage_page == PAGE_DESKTOP && item.data == USAGE_KBD) begin
          kbd_seen_next = 1'b1;
        end
      end
      ITEM_MAIN: begin
        if (item.tag == MTAG_IN_FIELD) begin
          if (on_key_page && is_var && !is_const && field_size == 32'd1 && !mod_found) begin
            mod_found_next = 1'b1;
            mod_off_next   = offset;
          end else if (on_key_page && !is_var && !is_const && field_size == 32'd8
                       && !key_found) begin
            key_found_next = 1'b1;
            key_off_next   = offset;
            key_slots_next = field_count;
          end
          // saturate at all ones
          if (product[63:32] != 32'd0 || sum[32]) begin
            bit_pos_next = '1;
          end else begin
            bit_pos_next = sum[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      usage_page  <= '0;
      field_size  <= '0;
      field_count <= '0;
      kbd_seen    <= 1'b0;
      id_prefix   <= 1'b0;
      bit_pos     <= '0;
      rpt_id      <= '0;
      mod_found   <= 1'b0;
      key_found   <= 1'b0;
      key_slots   <= '0;
      product     <= '0;
    end else if (item_pop) begin
      if (item.last) begin
        usage_page  <= '0;
        field_size  <= '0;
        field_count <= '0;
        kbd_seen    <= 1'b0;
        id_prefix   <= 1'b0;
        bit_pos     <= '0;
        rpt_id      <= '0;
        mod_found   <= 1'b0;
        key_found   <= 1'b0;
        key_slots   <= '0;
        product     <= '0;
      end else begin
        usage_page  <= usage_page_next;
        field_size  <= field_size_next;
        field_count <= field_count_next;
        kbd_seen    <= kbd_seen_next;
        id_prefix   <= id_prefix_next;
        bit_pos     <= bit_pos_next;
        rpt_id      <= rpt_id_next;
        mod_found   <= mod_found_next;
        key_found   <= key_found_next;
        key_slots   <= key_slots_next;
        if (mul_load) begin
          product <= mul_a * mul_b;
        end
      end
    end
  end

  // offsets are qualified by their found flags
  always_ff @(posedge clk) begin
    if (item_pop) begin
      mod_off <= mod_off_next;
      key_off <= key_off_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_pop && item.last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && item.last) begin
      out_kbd       <= kbd_seen_next && key_found_next;
      out_rpt_id    <= rpt_id_next;
      out_mod_off   <= mod_found_next ? {1'b0, mod_off_next} : '1;
      out_key_off   <= key_found_next ? {1'b0, key_off_next} : '1;
      out_key_slots <= key_slots_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kbd;
  assign m_tdata  = {2'b00, out_key_slots, out_key_off, out_mod_off, out_rpt_id};

endmodule

// ===== design/hid_keyboard_descriptor_parser.sv =====
// ----------------------------------------------------------------------------
// hid_keyboard_descriptor_parser
// Finds the keyboard report layout in a USB HID report descriptor.
// ----------------------------------------------------------------------------
// Descriptor bytes enter one per transfer on the s_ side, s_tlast on the
// final byte. A framer assembles short items and hands them through a
// two-entry queue to an executor, which tracks the global state and the
// running bit position and, on the item that holds the last byte, loads the
// layout into the output register and clears itself for the next descriptor.
// The block takes one byte per cycle; a byte is held back only while the
// queue is full, which happens when the output register is still waiting on
// m_tready when a final item reaches the executor. m_tvalid rises once the
// final item has passed through the queue and been loaded into the output
// register, later only while an earlier layout still waits on m_tready.
module hid_keyboard_descriptor_parser
  import hkdp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // desc_byte [7:0]
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // rpt id [31:0], modifier byte offset [62:32], keycode offset [93:63],
  // keycode slots [125:94], zero [127:126]
  output logic [127:0] m_tdata,
  output logic [0:0]   m_tuser    // keyboard flag [0]
);

  logic  byte_fire;
  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  assign s_tready  = !q_full;
  assign byte_fire = s_tvalid && s_tready;

  hkdp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_fire (byte_fire),
    .desc_byte (s_tdata),
    .last_byte (s_tlast),
    .item_push (push),
    .item      (push_item)
  );

  hkdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  hkdp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (head_valid),
    .item       (head_item),
    .item_pop   (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule
